FILE: rtl/core/key_list_table_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef KEY_LIST_TABLE_UNIT_DEFINES_SVH
`define KEY_LIST_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define KLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("key list table check failed");

// Next-cycle implication under an active-low reset.
`define KLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("key list table check failed");

`endif

FILE: rtl/core/kltu_pkg.sv
package kltu_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned IDX_W    = 7;

  // All ones in the index field reads as -1.
  localparam logic [IDX_W-1:0] NO_INDEX = '1;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT        = 3'd0,
    OP_INSERT_UNIQUE = 3'd1,
    OP_LOCATE        = 3'd2,
    OP_ZERO          = 3'd3,
    OP_REMOVE        = 3'd4,
    OP_TRUNCATE      = 3'd5,
    OP_RESET         = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

endpackage

FILE: rtl/core/key_list_table_unit.sv
// Ordered key list with a fill length, held in a single-port-write RAM.
// Command channel: a transaction is taken at a rising edge with start_i high
// and busy_o low; func_i, key_i and new_length_i are sampled there.
// Result channel: valid_o is high for exactly one cycle with index_o,
// removed_count_o, overflow_o and length_o; the receiver cannot stall it.
// Insert, truncate, reset and the unused code finish without a walk: the result
// shows in the cycle after the transaction and busy_o stays low, so such
// commands may follow each other in every cycle.
// Locate, insert unique, zero and remove walk the stored entries through
// one RAM read port and one key comparator, one entry per cycle: busy_o is
// high while the walk runs, and the result shows as busy_o falls.
// Locate walks down from the top and stops at the first match.
// Reset clears the length; entries at or beyond the length are never read,
// so the RAM needs no clearing pass. An append to a full list is refused with
// overflow_o set and index_o at -1.
module key_list_table_unit
  import kltu_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [IDX_W-1:0]    new_length_i,
  output logic                valid_o,
  output logic [IDX_W-1:0]    index_o,
  output logic [IDX_W-1:0]    removed_count_o,
  output logic                overflow_o,
  output logic [IDX_W-1:0]    length_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > IDX_W) ? CW : IDX_W;

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [AW-1:0]        raddr_q, raddr_d;
  logic [AW-1:0]        paddr_q;
  logic [KEY_WIDTH-1:0] rdata_q;
  logic                 pend_q, pend_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        rm_q, rm_d;
  logic                 valid_q, valid_d;
  logic [IDX_W-1:0]     index_q, index_d;
  logic [IDX_W-1:0]     removed_q, removed_d;
  logic                 ovf_q, ovf_d;
  logic [IDX_W-1:0]     len_q, len_d;

  logic                 re, we, finish, full, match, walk_down;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [KEY_WIDTH-1:0] key_in;
  op_e                  op_in;

  assign key_in    = KEY_WIDTH'(key_i);
  assign op_in     = op_e'(func_i);
  assign full      = (count_q == CW'(DEPTH));
  assign match     = (rdata_q == key_q);
  assign walk_down = (op_q == OP_LOCATE) || (op_q == OP_INSERT_UNIQUE);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    count_d   = count_q;
    rem_d     = rem_q;
    raddr_d   = raddr_q;
    wr_d      = wr_q;
    rm_d      = rm_q;
    valid_d   = 1'b0;
    index_d   = index_q;
    removed_d = removed_q;
    ovf_d     = ovf_q;
    len_d     = len_q;
    re        = 1'b0;
    we        = 1'b0;
    waddr     = AW'(count_q);
    wdata     = key_q;
    finish    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d      = op_in;
          key_d     = key_in;
          rem_d     = count_q;
          wr_d      = '0;
          rm_d      = '0;
          index_d   = '0;
          removed_d = '0;
          ovf_d     = 1'b0;
          case (op_in)
            OP_INSERT: begin
              valid_d = 1'b1;
              if (full) begin
                ovf_d   = 1'b1;
                index_d = NO_INDEX;
              end else begin
                we      = 1'b1;
                wdata   = key_in;
                index_d = IDX_W'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_INSERT_UNIQUE, OP_LOCATE: begin
              raddr_d = AW'(count_q - 1'b1);
              state_d = S_WALK;
            end
            OP_ZERO, OP_REMOVE: begin
              raddr_d = '0;
              state_d = S_WALK;
            end
            OP_TRUNCATE: begin
              valid_d = 1'b1;
              if (CMP_W'(new_length_i) < CMP_W'(count_q)) begin
                count_d = CW'(new_length_i);
              end
            end
            OP_RESET: begin
              valid_d = 1'b1;
              count_d = '0;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        // Issue the next read while the previous entry is compared.
        if (rem_q != '0) begin
          re      = 1'b1;
          rem_d   = rem_q - 1'b1;
          raddr_d = walk_down ? (raddr_q - 1'b1) : (raddr_q + 1'b1);
        end
        case (op_q)
          OP_INSERT_UNIQUE, OP_LOCATE: begin
            if (pend_q && match) begin
              finish  = 1'b1;
              index_d = IDX_W'(paddr_q);
            end else if ((rem_q == '0) && !pend_q) begin
              finish  = 1'b1;
              index_d = NO_INDEX;
              if (op_q == OP_INSERT_UNIQUE) begin
                if (full) begin
                  ovf_d = 1'b1;
                end else begin
                  we      = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end
            end
          end
          OP_ZERO: begin
            if (pend_q && match) begin
              we    = 1'b1;
              waddr = paddr_q;
              wdata = '0;
            end
            finish = (rem_q == '0) && !pend_q;
          end
          OP_REMOVE: begin
            // Keep non-matching entries packed at the write pointer.
            if (pend_q) begin
              if (match) begin
                rm_d = rm_q + 1'b1;
              end else begin
                we    = 1'b1;
                waddr = AW'(wr_q);
                wdata = rdata_q;
                wr_d  = wr_q + 1'b1;
              end
            end
            if ((rem_q == '0) && !pend_q) begin
              finish    = 1'b1;
              count_d   = wr_q;
              removed_d = IDX_W'(rm_q);
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_d = S_IDLE;
          valid_d = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (valid_d) begin
      len_d = IDX_W'(count_d);
    end
    // Drop reads in flight when the walk ends early.
    pend_d = re && !finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    rem_q     <= rem_d;
    raddr_q   <= raddr_d;
    wr_q      <= wr_d;
    rm_q      <= rm_d;
    index_q   <= index_d;
    removed_q <= removed_d;
    ovf_q     <= ovf_d;
    len_q     <= len_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr_q];
      paddr_q <= raddr_q;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign index_o         = index_q;
  assign removed_count_o = removed_q;
  assign overflow_o      = ovf_q;
  assign length_o        = len_q;

endmodule

FILE: rtl/core/kltu_checker.sv
`include "key_list_table_unit_defines.svh"

module kltu_checker
  import kltu_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                valid_o,
  input logic [IDX_W-1:0]    index_o,
  input logic [IDX_W-1:0]    removed_count_o,
  input logic                overflow_o
);

  // Every transaction either answers at once or holds the block busy.
  `KLT_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o, valid_o || busy_o)

  // The end of a walk always delivers its result.
  `KLT_ASSERT_IMP(a_walk_result, clk_i, rst_ni, $fell(busy_o), valid_o)

  // A refused append reports no position.
  `KLT_ASSERT_IMP(a_overflow_index, clk_i, rst_ni, valid_o && overflow_o, index_o == NO_INDEX)

  // A remove count comes only with a zero index.
  `KLT_ASSERT_IMP(a_remove_index, clk_i, rst_ni,
                  valid_o && (removed_count_o != '0), index_o == '0 && !overflow_o)

endmodule

bind key_list_table_unit kltu_checker u_kltu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .valid_o         (valid_o),
  .index_o         (index_o),
  .removed_count_o (removed_count_o),
  .overflow_o      (overflow_o)
);
